@@ src/tcp_option_scanner_defines.svh @@
// Assertion macros shared by the checker of the TCP option scanner.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TCP_OPTION_SCANNER_DEFINES_SVH
`define TCP_OPTION_SCANNER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define TOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcp_option_scanner: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define TOS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcp_option_scanner: same-cycle check failed");

`endif

@@ src/tos_pkg.sv @@
// Types and constants of the TCP option scanner.
// No dependencies; used by tos_in_if and by every module except tos_checker.
`timescale 1ns / 1ps

package tos_pkg;

  localparam int unsigned MAX_OPTION_BYTES = 40;
  localparam int unsigned WS_LIMIT         = 14;
  localparam int unsigned TS_WORD_BYTES    = 4;

  localparam int unsigned LEFT_W = 6;
  // Option length is at most MAX_OPTION_BYTES + 1 after the length check.
  localparam int unsigned LEN_W  = $clog2(MAX_OPTION_BYTES + 2);
  localparam int unsigned BI_W   = LEN_W;

  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_WS  = 8'd3;
  localparam logic [7:0] KIND_TS  = 8'd8;
  localparam logic [7:0] LEN_WS   = 8'd3;
  localparam logic [7:0] LEN_TS   = 8'd10;

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_BODY,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    STOP_DONE,
    STOP_EOL,
    STOP_CUT,
    STOP_BADLEN
  } stop_e;

  typedef struct packed {
    logic        has_timestamp;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        has_window_scale;
    logic [3:0]  window_shift;
    stop_e       stop_reason;
  } res_t;

endpackage

@@ src/tos_if.sv @@
// Valid/ready channel interfaces of the TCP option scanner.
// Depends on tos_pkg for field widths.
`timescale 1ns / 1ps

interface tos_in_if import tos_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [7:0]        opt_byte;
  logic [LEFT_W-1:0] bytes_left;

  modport source (output valid, action, opt_byte, bytes_left, input ready);
  modport sink   (input valid, action, opt_byte, bytes_left, output ready);
endinterface

interface tos_out_if;
  logic        valid;
  logic        ready;
  logic        has_timestamp;
  logic [31:0] ts_value;
  logic [31:0] ts_echo;
  logic        has_window_scale;
  logic [3:0]  window_shift;
  logic [1:0]  stop_reason;

  modport source (output valid, has_timestamp, ts_value, ts_echo, has_window_scale,
                  window_shift, stop_reason, input ready);
  modport sink   (input valid, has_timestamp, ts_value, ts_echo, has_window_scale,
                  window_shift, stop_reason, output ready);
endinterface

@@ src/tos_scan_core.sv @@
// Scan state and per-byte next-state logic of the TCP option scanner.
// Depends on tos_pkg.
`timescale 1ns / 1ps

module tos_scan_core import tos_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              action_i,
  input  logic [7:0]        byte_i,
  input  logic [LEFT_W-1:0] left_i,
  output logic              last_o,
  output res_t              res_o
);

  phase_e           phase_q, phase_scan, phase_d;
  stop_e            stop_q, stop_d;
  logic [7:0]       kind_q, kind_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [BI_W-1:0]  bi_q, bi_d, bi_inc;
  logic [31:0]      tsv_q, tsv_d, tse_q, tse_d;
  logic             ts_seen_q, ts_seen_d, ws_seen_q, ws_seen_d;
  logic [3:0]       ws_shift_q, ws_shift_d;
  logic [LEFT_W-1:0] lim;
  logic             len_bad, body_done, ts_opt;

  assign lim       = (left_i > LEFT_W'(MAX_OPTION_BYTES)) ? LEFT_W'(MAX_OPTION_BYTES) : left_i;
  assign len_bad   = (byte_i < 8'd2) || (byte_i > (8'(lim) + 8'd1));
  assign bi_inc    = bi_q + BI_W'(1);
  assign body_done = ((BI_W + 1)'(bi_inc) + (BI_W + 1)'(2)) >= (BI_W + 1)'(len_q);
  assign ts_opt    = (kind_q == KIND_TS) && (8'(len_q) == LEN_TS);
  assign last_o    = action_i || (left_i == LEFT_W'(1));

  // Next phase.
  always_comb begin
    phase_scan = phase_q;
    unique case (phase_q)
      PH_KIND: begin
        priority if (byte_i == KIND_EOL) phase_scan = PH_STOP;
        else if (byte_i == KIND_NOP) phase_scan = PH_KIND;
        else if (lim < LEFT_W'(2)) phase_scan = PH_STOP;
        else phase_scan = PH_LEN;
      end
      PH_LEN: begin
        priority if (len_bad) phase_scan = PH_STOP;
        else if (byte_i == 8'd2) phase_scan = PH_KIND;
        else phase_scan = PH_BODY;
      end
      PH_BODY: begin
        if (body_done) phase_scan = PH_KIND;
      end
      PH_STOP: phase_scan = PH_STOP;
      default: phase_scan = PH_KIND;
    endcase
    phase_d = last_o ? PH_KIND : phase_scan;
  end

  // Captured fields and report.
  always_comb begin
    stop_d     = stop_q;
    kind_d     = kind_q;
    len_d      = len_q;
    bi_d       = bi_q;
    tsv_d      = tsv_q;
    tse_d      = tse_q;
    ts_seen_d  = ts_seen_q;
    ws_seen_d  = ws_seen_q;
    ws_shift_d = ws_shift_q;
    unique case (phase_q)
      PH_KIND: begin
        priority if (byte_i == KIND_EOL) stop_d = STOP_EOL;
        else if (byte_i == KIND_NOP) stop_d = stop_q;
        else if (lim < LEFT_W'(2)) stop_d = STOP_CUT;
        else kind_d = byte_i;
      end
      PH_LEN: begin
        if (len_bad) begin
          stop_d = STOP_BADLEN;
        end else begin
          len_d = byte_i[LEN_W-1:0];
          bi_d  = '0;
          if ((kind_q == KIND_TS) && (byte_i == LEN_TS)) begin
            tsv_d     = '0;
            tse_d     = '0;
            ts_seen_d = 1'b0;
          end
        end
      end
      PH_BODY: begin
        if ((kind_q == KIND_WS) && (8'(len_q) == LEN_WS) && (bi_q == '0)) begin
          ws_shift_d = (byte_i > 8'(WS_LIMIT)) ? 4'(WS_LIMIT) : byte_i[3:0];
          ws_seen_d  = 1'b1;
        end
        if (ts_opt) begin
          if (bi_q < BI_W'(TS_WORD_BYTES)) begin
            tsv_d = {tsv_q[23:0], byte_i};
          end else if (bi_q < BI_W'(2 * TS_WORD_BYTES)) begin
            tse_d = {tse_q[23:0], byte_i};
          end
          if (bi_q == BI_W'(2 * TS_WORD_BYTES - 1)) ts_seen_d = 1'b1;
        end
        bi_d = bi_inc;
      end
      PH_STOP: stop_d = stop_q;
      default: stop_d = stop_q;
    endcase

    if (action_i) begin
      res_o = '0;
    end else begin
      res_o.has_timestamp    = ts_seen_d;
      res_o.ts_value         = ts_seen_d ? tsv_d : '0;
      res_o.ts_echo          = ts_seen_d ? tse_d : '0;
      res_o.has_window_scale = ws_seen_d;
      res_o.window_shift     = ws_seen_d ? ws_shift_d : '0;
      unique case (phase_scan)
        PH_STOP: res_o.stop_reason = stop_d;
        PH_KIND: res_o.stop_reason = STOP_DONE;
        default: res_o.stop_reason = STOP_BADLEN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_KIND;
      stop_q    <= STOP_DONE;
      ts_seen_q <= 1'b0;
      ws_seen_q <= 1'b0;
    end else if (step_i) begin
      if (action_i) begin
        phase_q <= PH_KIND;
      end else begin
        phase_q <= phase_d;
      end
      stop_q    <= last_o ? STOP_DONE : stop_d;
      ts_seen_q <= last_o ? 1'b0 : ts_seen_d;
      ws_seen_q <= last_o ? 1'b0 : ws_seen_d;
    end
  end

  // Payload registers; their contents only matter behind the flags above.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      kind_q     <= kind_d;
      len_q      <= len_d;
      bi_q       <= bi_d;
      tsv_q      <= tsv_d;
      tse_q      <= tse_d;
      ws_shift_q <= ws_shift_d;
    end
  end

endmodule

@@ src/tos_out_reg.sv @@
// Result register of the TCP option scanner, driving the output channel.
// Depends on tos_pkg and tos_out_if.
`timescale 1ns / 1ps

module tos_out_reg import tos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       free_o,
  tos_out_if.source  out_if
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || out_if.ready;
  assign valid_d = load_i || (valid_q && !out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_if.valid            = valid_q;
  assign out_if.has_timestamp    = res_q.has_timestamp;
  assign out_if.ts_value         = res_q.ts_value;
  assign out_if.ts_echo          = res_q.ts_echo;
  assign out_if.has_window_scale = res_q.has_window_scale;
  assign out_if.window_shift     = res_q.window_shift;
  assign out_if.stop_reason      = res_q.stop_reason;

endmodule

@@ src/tcp_option_scanner.sv @@
// Each accepted item waits in the input register and is scanned from there; its report,
// if any, is loaded into the result register that drives the output.
// Throughput: one item per cycle. Bytes that produce no report keep flowing while a report
// waits on the output; only a last byte or an empty-area item waits for the result register.
// Reset (rst_ni low, asynchronous) clears the scan state, valid flags and pending items.
`timescale 1ns / 1ps

module tcp_option_scanner import tos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tos_in_if.sink    in_if,
  tos_out_if.source out_if
);

  // Input register: one option byte (or an empty-area marker) waiting to be scanned.
  logic              in_valid_q;
  logic              action_q;
  logic [7:0]        byte_q;
  logic [LEFT_W-1:0] left_q;

  logic in_take;
  logic step;
  logic last;
  logic out_free;
  res_t res;

  // The held item advances when it produces no report, or when the result register
  // can take its report in this cycle. The input register refills whenever it empties.
  assign step        = in_valid_q && (!last || out_free);
  assign in_if.ready = !in_valid_q || step;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= in_if.action;
      byte_q   <= in_if.opt_byte;
      left_q   <= in_if.bytes_left;
    end
  end

  // The scan state moves by one byte on each step. The report for a last byte or an
  // empty-area item comes out of the same combinational pass.
  tos_scan_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .action_i (action_q),
    .byte_i   (byte_q),
    .left_i   (left_q),
    .last_o   (last),
    .res_o    (res)
  );

  // The result register holds a report until the sink takes it.
  tos_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && last),
    .res_i  (res),
    .free_o (out_free),
    .out_if (out_if)
  );

endmodule

@@ src/tos_checker.sv @@
// Port-level checks of the TCP option scanner, bound to the top level.
// Depends on tcp_option_scanner_defines.svh and tcp_option_scanner.
`timescale 1ns / 1ps
`include "tcp_option_scanner_defines.svh"

module tos_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        has_timestamp_i,
  input logic [31:0] ts_value_i,
  input logic [31:0] ts_echo_i,
  input logic        has_window_scale_i,
  input logic [3:0]  window_shift_i,
  input logic [1:0]  stop_reason_i
);

  `TOS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `TOS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(ts_value_i) && $stable(stop_reason_i))
  `TOS_ASSERT_NOW(a_ts_zero, clk_i, rst_ni, out_valid_i && !has_timestamp_i, (ts_value_i == 32'd0) && (ts_echo_i == 32'd0))
  `TOS_ASSERT_NOW(a_ws_range, clk_i, rst_ni, out_valid_i, (window_shift_i <= 4'd14) && (has_window_scale_i || (window_shift_i == 4'd0)))

endmodule

bind tcp_option_scanner tos_checker u_tos_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_if.valid),
  .out_ready_i        (out_if.ready),
  .has_timestamp_i    (out_if.has_timestamp),
  .ts_value_i         (out_if.ts_value),
  .ts_echo_i          (out_if.ts_echo),
  .has_window_scale_i (out_if.has_window_scale),
  .window_shift_i     (out_if.window_shift),
  .stop_reason_i      (out_if.stop_reason)
);
